// ===== hdl/mrfr_pkg.sv =====
// Shared types, constants and the CRC-16/MODBUS byte update for the Modbus RTU
// frame receiver. No dependencies; the design modules refer to it by scoped names.
package mrfr_pkg;

	localparam int MAX_FRAME_BYTES = 256;
	// The byte counter saturates one past the largest legal frame.
	localparam int CNT_W = $clog2(MAX_FRAME_BYTES + 2);

	localparam logic [15:0] CRC_INIT = 16'hFFFF;
	localparam logic [15:0] CRC_POLY = 16'hA001;

	localparam logic [7:0] FN_READ_MULTI   = 8'h03;
	localparam logic [7:0] FN_WRITE_SINGLE = 8'h06;
	localparam logic [7:0] FN_WRITE_MULTI  = 8'h10;

	// Byte positions within a request.
	localparam logic [CNT_W-1:0] POS_ADDR     = CNT_W'(0);
	localparam logic [CNT_W-1:0] POS_FUNC     = CNT_W'(1);
	localparam logic [CNT_W-1:0] POS_WORD_A_H = CNT_W'(2);
	localparam logic [CNT_W-1:0] POS_WORD_A_L = CNT_W'(3);
	localparam logic [CNT_W-1:0] POS_WORD_B_H = CNT_W'(4);
	localparam logic [CNT_W-1:0] POS_WORD_B_L = CNT_W'(5);
	localparam logic [CNT_W-1:0] POS_COUNT    = CNT_W'(6);

	// Address, function code and the two CRC bytes surround the data field.
	localparam logic [CNT_W-1:0] FRAME_OVERHEAD = CNT_W'(4);
	localparam logic [7:0]       SINGLE_DATA_LEN = 8'd4;
	// Start address, register count and byte count precede the values.
	localparam logic [8:0]       MULTI_HEAD_LEN = 9'd5;

	typedef enum logic [1:0] {
		ST_OK       = 2'd0,
		ST_CRC_ERR  = 2'd1,
		ST_FUNC_ERR = 2'd2,
		ST_LEN_ERR  = 2'd3
	} status_t;

	typedef struct packed {
		logic [15:0]      crc;
		logic [CNT_W-1:0] cnt;
		logic [7:0]       addr;
		logic [7:0]       func;
		logic [15:0]      word_a;
		logic [15:0]      word_b;
		logic [7:0]       count_byte;
	} frame_state_t;

	localparam frame_state_t FRAME_CLEAR = '{
		crc: CRC_INIT, cnt: '0, addr: '0, func: '0,
		word_a: '0, word_b: '0, count_byte: '0
	};

	typedef struct packed {
		status_t     status;
		logic [7:0]  slave_address;
		logic [7:0]  function_code;
		logic [7:0]  data_length;
		logic [15:0] first_word;
		logic [15:0] second_word;
		logic [7:0]  value_byte_count;
	} result_t;

	// One byte of reflected CRC-16/MODBUS, eight shift steps unrolled.
	function automatic logic [15:0] crc_step(input logic [15:0] crc, input logic [7:0] b);
		logic [15:0] c;
		c = crc ^ {8'h00, b};
		for (int k = 0; k < 8; k++) begin
			c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
		end
		return c;
	endfunction

endpackage

// ===== hdl/mrfr_if.sv =====
// Valid/ready channel interfaces of the Modbus RTU frame receiver: the byte
// stream in and the per-frame result out. No dependencies.
interface mrfr_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] rx_byte;
	logic       end_of_frame;

	modport source (output valid, output rx_byte, output end_of_frame, input ready);
	modport sink   (input valid, input rx_byte, input end_of_frame, output ready);
endinterface

interface mrfr_result_if;
	logic        valid;
	logic        ready;
	logic [1:0]  status;
	logic [7:0]  slave_address;
	logic [7:0]  function_code;
	logic [7:0]  data_length;
	logic [15:0] first_word;
	logic [15:0] second_word;
	logic [7:0]  value_byte_count;

	modport source (output valid, output status, output slave_address, output function_code,
		output data_length, output first_word, output second_word,
		output value_byte_count, input ready);
	modport sink   (input valid, input status, input slave_address, input function_code,
		input data_length, input first_word, input second_word,
		input value_byte_count, output ready);
endinterface

// ===== hdl/mrfr_accum.sv =====
// Per-frame accumulator: running CRC, saturating byte count and header fields.
// Depends on mrfr_pkg for the state type and the CRC byte update.
module mrfr_accum (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  take,
	input  logic [7:0]            rx_byte,
	input  logic                  end_of_frame,
	output mrfr_pkg::frame_state_t nxt
);

	mrfr_pkg::frame_state_t cur_q;

	always_comb begin
		nxt     = cur_q;
		nxt.crc = mrfr_pkg::crc_step(cur_q.crc, rx_byte);
		case (cur_q.cnt)
			mrfr_pkg::POS_ADDR:     nxt.addr = rx_byte;
			mrfr_pkg::POS_FUNC:     nxt.func = rx_byte;
			mrfr_pkg::POS_WORD_A_H: nxt.word_a[15:8] = rx_byte;
			mrfr_pkg::POS_WORD_A_L: nxt.word_a[7:0] = rx_byte;
			mrfr_pkg::POS_WORD_B_H: nxt.word_b[15:8] = rx_byte;
			mrfr_pkg::POS_WORD_B_L: nxt.word_b[7:0] = rx_byte;
			mrfr_pkg::POS_COUNT:    nxt.count_byte = rx_byte;
			default: ;
		endcase
		if (cur_q.cnt != mrfr_pkg::CNT_W'(mrfr_pkg::MAX_FRAME_BYTES + 1)) begin
			nxt.cnt = cur_q.cnt + mrfr_pkg::CNT_W'(1);
		end
	end

	// The last byte of a frame starts the next one from a clean state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_q <= mrfr_pkg::FRAME_CLEAR;
		end else if (take) begin
			cur_q <= end_of_frame ? mrfr_pkg::FRAME_CLEAR : nxt;
		end
	end

endmodule

// ===== hdl/mrfr_check.sv =====
// Frame checker: turns the accumulated state of a finished frame into its
// status and returned fields. Purely combinational; depends on mrfr_pkg.
module mrfr_check (
	input  mrfr_pkg::frame_state_t fs,
	output mrfr_pkg::result_t      res
);

	logic       bad_len;
	logic [7:0] dl;
	logic       fn_known;
	logic       multi_ok;

	always_comb begin
		bad_len  = (fs.cnt < mrfr_pkg::FRAME_OVERHEAD) ||
			(fs.cnt > mrfr_pkg::CNT_W'(mrfr_pkg::MAX_FRAME_BYTES));
		dl       = bad_len ? 8'd0 : 8'(fs.cnt - mrfr_pkg::FRAME_OVERHEAD);
		fn_known = (fs.func == mrfr_pkg::FN_READ_MULTI) ||
			(fs.func == mrfr_pkg::FN_WRITE_SINGLE) ||
			(fs.func == mrfr_pkg::FN_WRITE_MULTI);
		multi_ok = ({1'b0, dl} == ({1'b0, fs.count_byte} + mrfr_pkg::MULTI_HEAD_LEN)) &&
			({fs.word_b, 1'b0} == {9'd0, fs.count_byte});

		if (bad_len) begin
			res.status = mrfr_pkg::ST_LEN_ERR;
		end else if (fs.crc != 16'h0000) begin
			res.status = mrfr_pkg::ST_CRC_ERR;
		end else if (!fn_known) begin
			res.status = mrfr_pkg::ST_FUNC_ERR;
		end else if (fs.func == mrfr_pkg::FN_WRITE_MULTI) begin
			res.status = multi_ok ? mrfr_pkg::ST_OK : mrfr_pkg::ST_LEN_ERR;
		end else begin
			res.status = (dl == mrfr_pkg::SINGLE_DATA_LEN) ? mrfr_pkg::ST_OK
				: mrfr_pkg::ST_LEN_ERR;
		end

		res.slave_address    = (fs.cnt > mrfr_pkg::POS_ADDR) ? fs.addr : 8'd0;
		res.function_code    = (fs.cnt > mrfr_pkg::POS_FUNC) ? fs.func : 8'd0;
		res.data_length      = dl;
		// Data bytes beyond the data field read as zero.
		res.first_word[15:8] = (dl > 8'd0) ? fs.word_a[15:8] : 8'd0;
		res.first_word[7:0]  = (dl > 8'd1) ? fs.word_a[7:0] : 8'd0;
		res.second_word[15:8] = (dl > 8'd2) ? fs.word_b[15:8] : 8'd0;
		res.second_word[7:0]  = (dl > 8'd3) ? fs.word_b[7:0] : 8'd0;
		res.value_byte_count = (dl > 8'd4) ? fs.count_byte : 8'd0;
	end

endmodule

// ===== hdl/modbus_rtu_frame_receiver.sv =====
// Modbus RTU request receiver: one byte per request, one result per frame.
// Latency: the result is valid in the cycle after its last byte is accepted.
// Throughput: one byte per cycle; the byte CRC update, the frame check and the
// result register form a single registered pass, so only the last byte of a frame
// waits, and only while the previous result is held and res.ready is low.
// Reset (arst_n low, asynchronous): frame state cleared, CRC to 0xFFFF, no result.
module modbus_rtu_frame_receiver (
	input  logic   clk,
	input  logic   arst_n,
	mrfr_byte_if.sink     rx,
	mrfr_result_if.source res
);

	// A request is taken whenever its byte would not have to overwrite a result
	// that is still waiting: ordinary bytes never wait, the last byte of a frame
	// waits only while the result register is full and not being drained.
	logic                   out_valid_q;
	mrfr_pkg::result_t      res_q;
	mrfr_pkg::frame_state_t nxt;
	mrfr_pkg::result_t      chk;
	logic                   take;

	assign rx.ready = !(out_valid_q && !res.ready && rx.end_of_frame);
	assign take     = rx.valid && rx.ready;

	// Running CRC, byte count and header capture, one byte per cycle unless the last byte waits.
	mrfr_accum u_accum (
		.clk          (clk),
		.arst_n       (arst_n),
		.take         (take),
		.rx_byte      (rx.rx_byte),
		.end_of_frame (rx.end_of_frame),
		.nxt          (nxt)
	);

	// The checker looks at the state including the byte now being taken, so a
	// frame is judged in the same cycle its last byte arrives.
	mrfr_check u_check (
		.fs  (nxt),
		.res (chk)
	);

	// Result register: the only boundary between the byte side and the result side.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (take && rx.end_of_frame) begin
			out_valid_q <= 1'b1;
		end else if (res.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take && rx.end_of_frame) begin
			res_q <= chk;
		end
	end

	assign res.valid            = out_valid_q;
	assign res.status           = res_q.status;
	assign res.slave_address    = res_q.slave_address;
	assign res.function_code    = res_q.function_code;
	assign res.data_length      = res_q.data_length;
	assign res.first_word       = res_q.first_word;
	assign res.second_word      = res_q.second_word;
	assign res.value_byte_count = res_q.value_byte_count;

endmodule
